FILE: src/igalloc_pkg.sv
// Shared types, codes and constants of the inode group allocator.
`timescale 1ns / 1ps
`default_nettype none
package igalloc_pkg;

    localparam int MAX_GROUPS_DEF = 64;
    localparam int MAX_IPG_DEF    = 256;

    localparam int INUM_W  = 15;
    localparam int IPG_W   = 9;
    localparam int GRP_W   = 7;
    localparam int CNT_W   = 9;
    localparam int FB_W    = 16;
    localparam int GIDX_W  = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CHUNK    = 8;
    localparam int CHUNK_LG = 3;
    localparam int CNT_WORD_W = CNT_W + CNT_W + FB_W;

    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
    localparam logic [INUM_W-1:0] TOTAL_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_IPG    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 2'd3;

    localparam logic [IPG_W-1:0]  IPG_RST   = 9'd256;
    localparam logic [GRP_W-1:0]  GRP_RST   = 7'd64;
    localparam logic [INUM_W-1:0] FIRST_RST = 15'd11;
    localparam logic [INUM_W-1:0] TOTAL_RST = 15'd16384;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_LOAD  = 2'd2,
        OP_MARK  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_NO_SPACE = 3'd1,
        STS_CORRUPT  = 3'd2,
        STS_RANGE    = 3'd3,
        STS_CLEAR    = 3'd4,
        STS_BAD_FREE = 3'd5
    } stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_AVG_WAIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_END,
        S_PG_WAIT,
        S_MOD_WAIT,
        S_Q_RD,
        S_Q_CHK,
        S_L_NEXT,
        S_L_RD,
        S_L_CHK,
        S_INUM_WAIT,
        S_ROW_RD,
        S_SEARCH,
        S_MUL,
        S_ROW_SET,
        S_ACNT_RD,
        S_ALLOC_UPD,
        S_FREE_CHK,
        S_FCNT_RD,
        S_FREE_UPD,
        S_MARK_WR,
        S_LOAD_UPD,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_LATCH,
        ACT_DIV_AVG,
        ACT_DIV_PG,
        ACT_DIV_MOD,
        ACT_DIV_INUM,
        ACT_SCAN_INIT,
        ACT_CNT_RD_J,
        ACT_SCAN_EVAL,
        ACT_G_FROM_BEST,
        ACT_PROBE_INIT,
        ACT_CNT_RD_C,
        ACT_QUAD_STEP,
        ACT_LIN_INIT,
        ACT_LIN_STEP,
        ACT_G_FROM_CAND,
        ACT_GB_FROM_DIV,
        ACT_ROW_RD,
        ACT_SEARCH,
        ACT_MUL,
        ACT_ROW_WR_SET,
        ACT_ROW_WR_CLR,
        ACT_CNT_RD_G,
        ACT_CNT_RD_LOAD,
        ACT_CNT_WR_ALLOC,
        ACT_CNT_WR_FREE,
        ACT_CNT_WR_LOAD,
        ACT_EMIT
    } act_t;

    typedef struct packed {
        act_t  act;
        logic  code_we;
        stat_t code;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic dir;
        logic free_bad;
        logic mark_bad;
        logic load_bad;
        logic div_done;
        logic q_ge_groups;
        logic scan_last;
        logic best_valid;
        logic cand_free;
        logic step_lt_groups;
        logic bit_found;
        logic chunk_last;
        logic bit_set;
        logic inum_ok;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

FILE: src/igalloc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module igalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: src/igalloc_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module igalloc_div
    import igalloc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [INUM_W-1:0] dividend,
    input  wire logic [IPG_W-1:0]  divisor,
    output logic                   done,
    output logic      [INUM_W-1:0] quo,
    output logic      [IPG_W-1:0]  rem
);

    localparam int STEP_W = $clog2(INUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(INUM_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [INUM_W-1:0] q_reg;
    logic [INUM_W-1:0] q_next;
    logic [IPG_W-1:0]  r_reg;
    logic [IPG_W-1:0]  r_next;
    logic [IPG_W-1:0]  dvs_reg;
    logic [IPG_W:0]    trial;

    always_comb
    begin
        trial = {r_reg, q_reg[INUM_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            r_next = IPG_W'(trial - {1'b0, dvs_reg});
            q_next = {q_reg[INUM_W-2:0], 1'b1};
        end
        else
        begin
            r_next = trial[IPG_W-1:0];
            q_next = {q_reg[INUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            r_reg   <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign rem  = r_reg;

endmodule
`default_nettype wire

FILE: src/igalloc_ctrl.sv
// Sequencer of the inode group allocator.
`timescale 1ns / 1ps
`default_nettype none
module igalloc_ctrl
    import igalloc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd.act     = ACT_NONE;
        cmd.code_we = 1'b0;
        cmd.code    = STS_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.act    = ACT_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.op)
                    OP_ALLOC:
                    begin
                        if (sts.dir)
                        begin
                            cmd.act    = ACT_DIV_AVG;
                            state_next = S_AVG_WAIT;
                        end
                        else
                        begin
                            cmd.act    = ACT_DIV_PG;
                            state_next = S_PG_WAIT;
                        end
                    end
                    OP_FREE:
                    begin
                        if (sts.free_bad)
                        begin
                            cmd.code_we = 1'b1;
                            cmd.code    = STS_BAD_FREE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cmd.act    = ACT_DIV_INUM;
                            state_next = S_INUM_WAIT;
                        end
                    end
                    OP_LOAD:
                    begin
                        if (sts.load_bad)
                        begin
                            cmd.code_we = 1'b1;
                            cmd.code    = STS_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cmd.act    = ACT_CNT_RD_LOAD;
                            state_next = S_LOAD_UPD;
                        end
                    end
                    default:
                    begin
                        if (sts.mark_bad)
                        begin
                            cmd.code_we = 1'b1;
                            cmd.code    = STS_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cmd.act    = ACT_DIV_INUM;
                            state_next = S_INUM_WAIT;
                        end
                    end
                endcase
            end
            S_AVG_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.act    = ACT_SCAN_INIT;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.act    = ACT_CNT_RD_J;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.act    = ACT_SCAN_EVAL;
                state_next = sts.scan_last ? S_SCAN_END : S_SCAN_RD;
            end
            S_SCAN_END:
            begin
                if (sts.best_valid)
                begin
                    cmd.act    = ACT_G_FROM_BEST;
                    state_next = S_ROW_RD;
                end
                else
                begin
                    cmd.code_we = 1'b1;
                    cmd.code    = STS_NO_SPACE;
                    state_next  = S_DONE;
                end
            end
            S_PG_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.act    = ACT_DIV_MOD;
                    state_next = S_MOD_WAIT;
                end
            end
            S_MOD_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.act    = ACT_PROBE_INIT;
                    state_next = S_Q_RD;
                end
            end
            S_Q_RD:
            begin
                cmd.act    = ACT_CNT_RD_C;
                state_next = S_Q_CHK;
            end
            S_Q_CHK:
            begin
                if (sts.cand_free)
                begin
                    cmd.act    = ACT_G_FROM_CAND;
                    state_next = S_ROW_RD;
                end
                else if (sts.step_lt_groups)
                begin
                    cmd.act    = ACT_QUAD_STEP;
                    state_next = S_Q_RD;
                end
                else
                begin
                    cmd.act    = ACT_LIN_INIT;
                    state_next = S_L_NEXT;
                end
            end
            S_L_NEXT:
            begin
                if (sts.step_lt_groups)
                begin
                    cmd.act    = ACT_LIN_STEP;
                    state_next = S_L_RD;
                end
                else
                begin
                    cmd.code_we = 1'b1;
                    cmd.code    = STS_NO_SPACE;
                    state_next  = S_DONE;
                end
            end
            S_L_RD:
            begin
                cmd.act    = ACT_CNT_RD_C;
                state_next = S_L_CHK;
            end
            S_L_CHK:
            begin
                if (sts.cand_free)
                begin
                    cmd.act    = ACT_G_FROM_CAND;
                    state_next = S_ROW_RD;
                end
                else
                begin
                    state_next = S_L_NEXT;
                end
            end
            S_INUM_WAIT:
            begin
                if (sts.div_done)
                begin
                    if (sts.q_ge_groups)
                    begin
                        cmd.code_we = 1'b1;
                        cmd.code    = STS_RANGE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cmd.act    = ACT_GB_FROM_DIV;
                        state_next = S_ROW_RD;
                    end
                end
            end
            S_ROW_RD:
            begin
                cmd.act = ACT_ROW_RD;
                case (sts.op)
                    OP_ALLOC: state_next = S_SEARCH;
                    OP_FREE:  state_next = S_FREE_CHK;
                    default:  state_next = S_MARK_WR;
                endcase
            end
            S_SEARCH:
            begin
                cmd.act = ACT_SEARCH;
                if (sts.bit_found)
                begin
                    state_next = S_MUL;
                end
                else if (sts.chunk_last)
                begin
                    cmd.code_we = 1'b1;
                    cmd.code    = STS_CORRUPT;
                    state_next  = S_DONE;
                end
            end
            S_MUL:
            begin
                cmd.act    = ACT_MUL;
                state_next = S_ROW_SET;
            end
            S_ROW_SET:
            begin
                cmd.act = ACT_ROW_WR_SET;
                if (sts.inum_ok)
                begin
                    state_next = S_ACNT_RD;
                end
                else
                begin
                    cmd.code_we = 1'b1;
                    cmd.code    = STS_RANGE;
                    state_next  = S_DONE;
                end
            end
            S_ACNT_RD:
            begin
                cmd.act    = ACT_CNT_RD_G;
                state_next = S_ALLOC_UPD;
            end
            S_ALLOC_UPD:
            begin
                cmd.act     = ACT_CNT_WR_ALLOC;
                cmd.code_we = 1'b1;
                cmd.code    = STS_OK;
                state_next  = S_DONE;
            end
            S_FREE_CHK:
            begin
                if (sts.bit_set)
                begin
                    cmd.act    = ACT_ROW_WR_CLR;
                    state_next = S_FCNT_RD;
                end
                else
                begin
                    cmd.code_we = 1'b1;
                    cmd.code    = STS_CLEAR;
                    state_next  = S_DONE;
                end
            end
            S_FCNT_RD:
            begin
                cmd.act    = ACT_CNT_RD_G;
                state_next = S_FREE_UPD;
            end
            S_FREE_UPD:
            begin
                cmd.act     = ACT_CNT_WR_FREE;
                cmd.code_we = 1'b1;
                cmd.code    = STS_OK;
                state_next  = S_DONE;
            end
            S_MARK_WR:
            begin
                cmd.act     = ACT_ROW_WR_SET;
                cmd.code_we = 1'b1;
                cmd.code    = STS_OK;
                state_next  = S_DONE;
            end
            S_LOAD_UPD:
            begin
                cmd.act     = ACT_CNT_WR_LOAD;
                cmd.code_we = 1'b1;
                cmd.code    = STS_OK;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.act    = ACT_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: src/igalloc_dp.sv
// Datapath: configuration, counters, bitmap, divider, probe and search.
`timescale 1ns / 1ps
`default_nettype none
module igalloc_dp
    import igalloc_pkg::*;
#(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF,
    parameter int MAX_IPG    = MAX_IPG_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmd_t                 cmd,
    output sts_t                      sts,
    input  wire logic [1:0]           in_op,
    input  wire logic [INUM_W-1:0]    in_parent,
    input  wire logic [INUM_W-1:0]    in_inum,
    input  wire logic                 in_dir,
    input  wire logic [GIDX_W-1:0]    in_gidx,
    input  wire logic [CNT_W-1:0]     in_fiv,
    input  wire logic [CNT_W-1:0]     in_udv,
    input  wire logic [FB_W-1:0]      in_fbv,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [INUM_W-1:0]    cfg_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [INUM_W-1:0]    out_inode,
    output logic      [2:0]           out_status
);

    localparam int GW       = $clog2(MAX_GROUPS);
    localparam int BW       = $clog2(MAX_IPG);
    localparam int NCH      = (MAX_IPG + CHUNK - 1) / CHUNK;
    localparam int KW       = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int ROW_W    = NCH * CHUNK;
    localparam int BXW      = KW + CHUNK_LG + 1;
    localparam int NW       = GW + IPG_W + 1;
    localparam int CMPW     = (NW > INUM_W) ? NW : INUM_W;
    localparam int XW       = ((GW > GRP_W) ? GW : GRP_W) + 2;
    localparam int IPG_CAP  = (MAX_IPG > 511) ? 511 : MAX_IPG;
    localparam int GRP_CAP  = (MAX_GROUPS > 127) ? 127 : MAX_GROUPS;

    // configuration
    logic [IPG_W-1:0]  ipg_reg;
    logic [GRP_W-1:0]  grp_reg;
    logic [INUM_W-1:0] first_reg;
    logic [INUM_W-1:0] tot_reg;
    logic [IPG_W-1:0]  ipg_eff;
    logic [GRP_W-1:0]  grp_eff;

    // latched item
    op_t               op_reg;
    logic [INUM_W-1:0] par_reg;
    logic [INUM_W-1:0] inum_in_reg;
    logic              dir_reg;
    logic [GIDX_W-1:0] gidx_reg;
    logic [CNT_W-1:0]  fiv_reg;
    logic [CNT_W-1:0]  udv_reg;
    logic [FB_W-1:0]   fbv_reg;

    // working state
    logic [INUM_W-1:0] total_free_reg;
    logic [INUM_W-1:0] avg_reg;
    logic [GW-1:0]     j_reg;
    logic              best_v_reg;
    logic [GW-1:0]     best_g_reg;
    logic [FB_W-1:0]   best_fb_reg;
    logic [GW-1:0]     pg_reg;
    logic [GW-1:0]     cand_reg;
    logic [XW-1:0]     step_reg;
    logic [GW-1:0]     g_reg;
    logic [BW-1:0]     b_reg;
    logic [KW-1:0]     k_reg;
    logic [NW-1:0]     inum_reg;
    logic [INUM_W-1:0] res_inode_reg;
    stat_t             res_code_reg;
    logic              out_valid_reg;
    logic [INUM_W-1:0] out_inode_reg;
    stat_t             out_code_reg;

    // divider
    logic              div_start;
    logic [INUM_W-1:0] div_dividend;
    logic [IPG_W-1:0]  div_divisor;
    logic              div_done;
    logic [INUM_W-1:0] div_quo;
    logic [IPG_W-1:0]  div_rem;

    // counter store
    logic [MAX_GROUPS-1:0] cnt_vld_reg;
    logic                  cnt_rv_reg;
    logic                  cnt_re;
    logic [GW-1:0]         cnt_raddr;
    logic                  cnt_we;
    logic [GW-1:0]         cnt_waddr;
    logic [CNT_WORD_W-1:0] cnt_wdata;
    logic [CNT_WORD_W-1:0] cnt_rdata;
    logic [CNT_W-1:0]      cnt_fi;
    logic [CNT_W-1:0]      cnt_ud;
    logic [FB_W-1:0]       cnt_fb;
    logic [CNT_W-1:0]      new_fi;
    logic [CNT_W-1:0]      new_ud;
    logic [INUM_W-1:0]     new_total;
    logic signed [INUM_W+1:0] load_sum;

    // bitmap store
    logic [MAX_GROUPS-1:0] row_vld_reg;
    logic                  row_rv_reg;
    logic                  row_re;
    logic                  row_we;
    logic [ROW_W-1:0]      row_rdata;
    logic [ROW_W-1:0]      row_eff;
    logic [ROW_W-1:0]      row_wdata;
    logic [ROW_W-1:0]      bit_mask;
    logic [CHUNK-1:0]      chunk;
    logic [BXW-1:0]        chunk_base;
    logic                  found;
    logic [CHUNK_LG-1:0]   found_pos;
    logic [BXW-1:0]        found_idx;

    logic [XW-1:0]         quad_sum;
    logic [XW-1:0]         pg_inc;
    logic [XW-1:0]         cand_inc;
    logic [XW-1:0]         grp_x;
    logic                  qualifies;

    assign ipg_eff = (ipg_reg == '0) ? IPG_W'(1) :
                     (ipg_reg > IPG_W'(IPG_CAP)) ? IPG_W'(IPG_CAP) : ipg_reg;
    assign grp_eff = (grp_reg == '0) ? GRP_W'(1) :
                     (grp_reg > GRP_W'(GRP_CAP)) ? GRP_W'(GRP_CAP) : grp_reg;
    assign grp_x   = XW'(grp_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipg_reg   <= IPG_RST;
            grp_reg   <= GRP_RST;
            first_reg <= FIRST_RST;
            tot_reg   <= TOTAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IPG:    ipg_reg   <= cfg_data[IPG_W-1:0];
                CFG_GROUPS: grp_reg   <= cfg_data[GRP_W-1:0];
                CFG_FIRST:  first_reg <= cfg_data;
                CFG_TOTAL:  tot_reg   <= cfg_data;
                default:    ipg_reg   <= ipg_reg;
            endcase
        end
    end

    // divider operands
    always_comb
    begin
        div_start    = 1'b1;
        div_dividend = inum_in_reg - 1'b1;
        div_divisor  = ipg_eff;
        case (cmd.act)
            ACT_DIV_AVG:
            begin
                div_dividend = total_free_reg;
                div_divisor  = IPG_W'(grp_eff);
            end
            ACT_DIV_PG:
            begin
                div_dividend = (par_reg == '0) ? '0 : par_reg - 1'b1;
            end
            ACT_DIV_MOD:
            begin
                div_dividend = div_quo;
                div_divisor  = IPG_W'(grp_eff);
            end
            ACT_DIV_INUM:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    igalloc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // counter store access
    always_comb
    begin
        cnt_re    = 1'b1;
        cnt_raddr = g_reg;
        case (cmd.act)
            ACT_CNT_RD_J:    cnt_raddr = j_reg;
            ACT_CNT_RD_C:    cnt_raddr = cand_reg;
            ACT_CNT_RD_G:    cnt_raddr = g_reg;
            ACT_CNT_RD_LOAD: cnt_raddr = GW'(gidx_reg);
            default:         cnt_re    = 1'b0;
        endcase
    end

    assign cnt_fi = cnt_rv_reg ? cnt_rdata[CNT_W-1:0] : '0;
    assign cnt_ud = cnt_rv_reg ? cnt_rdata[2*CNT_W-1:CNT_W] : '0;
    assign cnt_fb = cnt_rv_reg ? cnt_rdata[CNT_WORD_W-1:2*CNT_W] : '0;

    assign load_sum = (INUM_W+2)'(total_free_reg) - (INUM_W+2)'(cnt_fi)
                    + (INUM_W+2)'(fiv_reg);

    always_comb
    begin
        cnt_we    = 1'b1;
        cnt_waddr = g_reg;
        new_fi    = cnt_fi;
        new_ud    = cnt_ud;
        new_total = total_free_reg;
        case (cmd.act)
            ACT_CNT_WR_ALLOC:
            begin
                new_fi    = (cnt_fi != '0) ? cnt_fi - 1'b1 : cnt_fi;
                new_ud    = (dir_reg && cnt_ud != CNT_MAX) ? cnt_ud + 1'b1 : cnt_ud;
                new_total = (total_free_reg != '0) ? total_free_reg - 1'b1 : total_free_reg;
            end
            ACT_CNT_WR_FREE:
            begin
                new_fi    = (cnt_fi != CNT_MAX) ? cnt_fi + 1'b1 : cnt_fi;
                new_ud    = (dir_reg && cnt_ud != '0) ? cnt_ud - 1'b1 : cnt_ud;
                new_total = (total_free_reg != TOTAL_MAX) ?
                            total_free_reg + 1'b1 : total_free_reg;
            end
            ACT_CNT_WR_LOAD:
            begin
                cnt_waddr = GW'(gidx_reg);
                new_fi    = fiv_reg;
                new_ud    = udv_reg;
                if (load_sum < 0)
                begin
                    new_total = '0;
                end
                else if (load_sum > (INUM_W+2)'(TOTAL_MAX))
                begin
                    new_total = TOTAL_MAX;
                end
                else
                begin
                    new_total = load_sum[INUM_W-1:0];
                end
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
        cnt_wdata = {(cmd.act == ACT_CNT_WR_LOAD) ? fbv_reg : cnt_fb, new_ud, new_fi};
    end

    igalloc_ram #(
        .WIDTH (CNT_WORD_W),
        .DEPTH (MAX_GROUPS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // bitmap store access
    assign row_re    = (cmd.act == ACT_ROW_RD);
    assign row_we    = (cmd.act == ACT_ROW_WR_SET) || (cmd.act == ACT_ROW_WR_CLR);
    assign row_eff   = row_rv_reg ? row_rdata : '0;
    assign bit_mask  = ROW_W'(1) << b_reg;
    assign row_wdata = (cmd.act == ACT_ROW_WR_SET) ? (row_eff | bit_mask)
                                                   : (row_eff & ~bit_mask);

    igalloc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_GROUPS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (g_reg),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (g_reg),
        .rdata (row_rdata)
    );

    // first clear bit of the current chunk below the group size
    assign chunk_base = BXW'({k_reg, {CHUNK_LG{1'b0}}});
    assign chunk      = row_eff[chunk_base[BXW-2:0] +: CHUNK];

    always_comb
    begin
        found     = 1'b0;
        found_pos = '0;
        for (int i = CHUNK - 1; i >= 0; i--)
        begin
            if (!chunk[i] && (chunk_base + BXW'(i)) < BXW'(ipg_eff))
            begin
                found     = 1'b1;
                found_pos = CHUNK_LG'(i);
            end
        end
    end

    assign found_idx = chunk_base + BXW'(found_pos);

    // probe arithmetic; a parent group in the last slot starts the linear walk at the parent group itself
    assign quad_sum = (XW'(cand_reg) + step_reg >= grp_x) ?
                      XW'(cand_reg) + step_reg - grp_x : XW'(cand_reg) + step_reg;
    assign pg_inc   = (XW'(pg_reg) + 1'b1 >= grp_x) ? XW'(pg_reg) : XW'(pg_reg) + 1'b1;
    assign cand_inc = (XW'(cand_reg) + 1'b1 >= grp_x) ? '0 : XW'(cand_reg) + 1'b1;

    assign qualifies = (cnt_fi != '0) && (INUM_W'(cnt_fi) >= avg_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_free_reg <= '0;
            cnt_vld_reg    <= '0;
            row_vld_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cnt_we)
            begin
                total_free_reg         <= new_total;
                cnt_vld_reg[cnt_waddr] <= 1'b1;
            end
            if (row_we)
            begin
                row_vld_reg[g_reg] <= 1'b1;
            end
            if (cmd.act == ACT_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_re)
        begin
            cnt_rv_reg <= cnt_vld_reg[cnt_raddr];
        end
        if (row_re)
        begin
            row_rv_reg <= row_vld_reg[g_reg];
        end
        if (cmd.code_we)
        begin
            res_code_reg <= cmd.code;
        end
        case (cmd.act)
            ACT_LATCH:
            begin
                op_reg        <= op_t'(in_op);
                par_reg       <= in_parent;
                inum_in_reg   <= in_inum;
                dir_reg       <= in_dir;
                gidx_reg      <= in_gidx;
                fiv_reg       <= in_fiv;
                udv_reg       <= in_udv;
                fbv_reg       <= in_fbv;
                res_inode_reg <= '0;
                res_code_reg  <= STS_OK;
            end
            ACT_SCAN_INIT:
            begin
                avg_reg    <= div_quo;
                j_reg      <= '0;
                best_v_reg <= 1'b0;
            end
            ACT_SCAN_EVAL:
            begin
                if (qualifies && (!best_v_reg || cnt_fb > best_fb_reg))
                begin
                    best_v_reg  <= 1'b1;
                    best_g_reg  <= j_reg;
                    best_fb_reg <= cnt_fb;
                end
                j_reg <= j_reg + 1'b1;
            end
            ACT_G_FROM_BEST:
            begin
                g_reg <= best_g_reg;
            end
            ACT_PROBE_INIT:
            begin
                pg_reg   <= GW'(div_rem);
                cand_reg <= GW'(div_rem);
                step_reg <= XW'(1);
            end
            ACT_QUAD_STEP:
            begin
                cand_reg <= GW'(quad_sum);
                step_reg <= step_reg << 1;
            end
            ACT_LIN_INIT:
            begin
                cand_reg <= GW'(pg_inc);
                step_reg <= XW'(2);
            end
            ACT_LIN_STEP:
            begin
                cand_reg <= GW'(cand_inc);
                step_reg <= step_reg + 1'b1;
            end
            ACT_G_FROM_CAND:
            begin
                g_reg <= cand_reg;
            end
            ACT_GB_FROM_DIV:
            begin
                g_reg <= GW'(div_quo);
                b_reg <= BW'(div_rem);
            end
            ACT_ROW_RD:
            begin
                k_reg <= '0;
            end
            ACT_SEARCH:
            begin
                if (found)
                begin
                    b_reg <= BW'(found_idx);
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            ACT_MUL:
            begin
                inum_reg <= NW'(g_reg) * NW'(ipg_eff) + NW'(b_reg) + NW'(1);
            end
            ACT_CNT_WR_ALLOC:
            begin
                res_inode_reg <= inum_reg[INUM_W-1:0];
            end
            ACT_EMIT:
            begin
                out_inode_reg <= res_inode_reg;
                out_code_reg  <= res_code_reg;
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    // status toward the sequencer
    assign sts.op             = op_reg;
    assign sts.dir            = dir_reg;
    assign sts.free_bad       = (inum_in_reg < first_reg) || (inum_in_reg > tot_reg)
                                || (inum_in_reg == '0);
    assign sts.mark_bad       = (inum_in_reg == '0) || (inum_in_reg > tot_reg);
    assign sts.load_bad       = (32'(gidx_reg) >= MAX_GROUPS);
    assign sts.div_done       = div_done;
    assign sts.q_ge_groups    = (div_quo >= INUM_W'(grp_eff));
    assign sts.scan_last      = (XW'(j_reg) == grp_x - 1'b1);
    assign sts.best_valid     = best_v_reg;
    assign sts.cand_free      = (cnt_fi != '0);
    assign sts.step_lt_groups = (step_reg < grp_x);
    assign sts.bit_found      = found;
    assign sts.chunk_last     = (chunk_base + BXW'(CHUNK) >= BXW'(ipg_eff));
    assign sts.bit_set        = row_eff[b_reg];
    assign sts.inum_ok        = (CMPW'(inum_reg) >= CMPW'(first_reg))
                                && (CMPW'(inum_reg) <= CMPW'(tot_reg));
    assign sts.out_free       = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_inode  = out_inode_reg;
    assign out_status = out_code_reg;

endmodule
`default_nettype wire

FILE: src/inode_group_allocator.sv
// Top level of the inode group allocator.
`timescale 1ns / 1ps
`default_nettype none
// Takes one request item at a time (allocate, free, load counters, mark used)
// and returns one result item per request carrying the allocated inode and a
// status code. Allocate, free and mark requests run through a shared restoring
// divider; the counter store and the bitmap store are single-write, single-read
// RAMs with registered reads. A directory allocation first divides for the
// average and scans the configured groups, a file allocation runs its two
// divisions and then probes groups; both then search the bitmap chunk by
// chunk and write back. Both stores start out clear through per-group valid
// bits, so no clearing pass follows reset. The result register lets a new
// request in while a result waits.
module inode_group_allocator
    import igalloc_pkg::*;
#(
    parameter int MAX_GROUPS           = MAX_GROUPS_DEF,
    parameter int MAX_INODES_PER_GROUP = MAX_IPG_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // parent_inode, inode_number, is_directory, group_index,
    // free_inodes_value, used_dirs_value, free_blocks_value, pad
    input  wire logic [71:0]          s_tdata,
    // operation
    input  wire logic [1:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // allocated_inode, status, pad
    output logic      [23:0]          m_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [INUM_W-1:0]    cfg_data
);

    cmd_t              cmd;
    sts_t              sts;
    logic [INUM_W-1:0] out_inode;
    logic [2:0]        out_status;

    assign cfg_ready = 1'b1;

    igalloc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    igalloc_dp #(
        .MAX_GROUPS (MAX_GROUPS),
        .MAX_IPG    (MAX_INODES_PER_GROUP)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tuser),
        .in_parent  (s_tdata[14:0]),
        .in_inum    (s_tdata[29:15]),
        .in_dir     (s_tdata[30]),
        .in_gidx    (s_tdata[36:31]),
        .in_fiv     (s_tdata[45:37]),
        .in_udv     (s_tdata[54:46]),
        .in_fbv     (s_tdata[70:55]),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_inode  (out_inode),
        .out_status (out_status)
    );

    assign m_tdata = {6'b0, out_status, out_inode};

endmodule
`default_nettype wire
